// ===== rtl/core/mecanum_wheel_speed_mixer_assert.svh =====
// Assertion macros used by the mecanum wheel speed mixer RTL.
`ifndef MECANUM_WHEEL_SPEED_MIXER_ASSERT_SVH
`define MECANUM_WHEEL_SPEED_MIXER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MWSM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mecanum mixer: implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MWSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mecanum mixer: next-cycle check failed");

`endif

// ===== rtl/core/mwsm_pkg.sv =====
// Shared types, constants and helper functions of the mecanum wheel speed mixer.
package mwsm_pkg;

	// Field and datapath widths.
	localparam int NUM_WHEELS  = 4;
	localparam int SPEED_W     = 16;
	localparam int LIMIT_W     = 15;
	localparam int RATIO_W     = 32;
	localparam int FRAC_W      = 16;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;

	// Rotation product: 15-bit yaw magnitude times a Q16.16 ratio.
	localparam int PROD_ROT_W = (SPEED_W - 1) + RATIO_W;
	localparam int ROT_W      = PROD_ROT_W - FRAC_W;
	// Wheel mix sum is signed and two bits wider than a rotation magnitude.
	localparam int SUM_W      = ROT_W + 2;
	localparam int MAG_W      = SUM_W - 1;
	// Wheel mix magnitude times the rpm ratio.
	localparam int PROD_RPM_W = MAG_W + RATIO_W;
	localparam int SCALED_W   = PROD_RPM_W - FRAC_W;
	// Peak magnitude and the scaling divider.
	localparam int PEAK_W     = SPEED_W;
	localparam int NUM_W      = PEAK_W + LIMIT_W;
	localparam int QUO_W      = LIMIT_W;
	localparam int DIV_STEPS  = 3;
	localparam int DIV_STAGES = QUO_W / DIV_STEPS;

	// Wheel positions inside the packed wheel arrays.
	localparam int WHEEL_FL = 0;
	localparam int WHEEL_FR = 1;
	localparam int WHEEL_RR = 2;
	localparam int WHEEL_RL = 3;

	typedef logic signed [SPEED_W-1:0] speed_t;

	// Chassis command carried by one input transfer.
	typedef struct packed {
		speed_t speed_forward;
		speed_t speed_sideways;
		speed_t rate_yaw;
	} cmd_t;

	// Wheel targets carried by one output transfer.
	typedef struct packed {
		speed_t rpm_front_left;
		speed_t rpm_front_right;
		speed_t rpm_rear_right;
		speed_t rpm_rear_left;
		logic   was_scaled;
	} wheel_t;

	// Configuration register file.
	typedef struct packed {
		logic [LIMIT_W-1:0] limit_forward;
		logic [LIMIT_W-1:0] limit_sideways;
		logic [LIMIT_W-1:0] limit_yaw;
		logic [RATIO_W-1:0] ratio_front;
		logic [RATIO_W-1:0] ratio_rear;
		logic [RATIO_W-1:0] ratio_rpm;
		logic [LIMIT_W-1:0] limit_wheel;
	} cfg_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LIMIT_FORWARD  = 3'd0,
		CFG_LIMIT_SIDEWAYS = 3'd1,
		CFG_LIMIT_YAW      = 3'd2,
		CFG_RATIO_FRONT    = 3'd3,
		CFG_RATIO_REAR     = 3'd4,
		CFG_RATIO_RPM      = 3'd5,
		CFG_LIMIT_WHEEL    = 3'd6
	} cfg_index_t;

	localparam cfg_t CFG_RESET = '{
		limit_forward:  15'd3500,
		limit_sideways: 15'd3500,
		limit_yaw:      15'd360,
		ratio_front:    32'd458752,
		ratio_rear:     32'd458752,
		ratio_rpm:      32'd434,
		limit_wheel:    15'd8500
	};

	// Saturated wheel speeds and their magnitudes.
	typedef struct packed {
		speed_t [NUM_WHEELS-1:0]             rpm;
		logic   [NUM_WHEELS-1:0][PEAK_W-1:0] mag;
	} mix_t;

	// Operands of the proportional scaling division.
	typedef struct packed {
		speed_t [NUM_WHEELS-1:0]            rpm;
		logic   [NUM_WHEELS-1:0][NUM_W-1:0] num;
		logic   [PEAK_W-1:0]                peak;
		logic                               scaled;
	} scale_t;

	// Partial state of the division as it walks down the divider stages.
	typedef struct packed {
		speed_t [NUM_WHEELS-1:0]             rpm;
		logic   [NUM_WHEELS-1:0][PEAK_W-1:0] rem;
		logic   [NUM_WHEELS-1:0][QUO_W-1:0]  low;
		logic   [NUM_WHEELS-1:0][QUO_W-1:0]  quo;
		logic   [PEAK_W-1:0]                 peak;
		logic                                scaled;
	} quo_t;

	// Clamp a signed axis value to the symmetric range of an unsigned limit.
	function automatic speed_t clamp_axis(input speed_t v, input logic [LIMIT_W-1:0] lim);
		logic signed [SPEED_W:0] v_ext;
		logic signed [SPEED_W:0] hi;
		logic signed [SPEED_W:0] lo;
		speed_t                  r;
		v_ext = (SPEED_W+1)'(v);
		hi    = $signed({{(SPEED_W+1-LIMIT_W){1'b0}}, lim});
		lo    = -hi;
		if (v_ext > hi) begin
			r = hi[SPEED_W-1:0];
		end else if (v_ext < lo) begin
			r = lo[SPEED_W-1:0];
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/mwsm_mix.sv =====
// Five-stage front end: axis clamp, rotation terms, wheel mix, rpm scaling, saturation.
module mwsm_mix (
	input  logic            clk,
	input  logic            arst_n,
	input  mwsm_pkg::cfg_t  cfg,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  mwsm_pkg::cmd_t  cmd,
	output logic            mix_valid,
	input  logic            mix_ready,
	output mwsm_pkg::mix_t  mix
);
	import mwsm_pkg::*;

	localparam logic [SCALED_W-1:0] POS_MAX = SCALED_W'((1 << (SPEED_W - 1)) - 1);
	localparam logic [SCALED_W-1:0] NEG_MAX = SCALED_W'(1 << (SPEED_W - 1));

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic load_s1, load_s2, load_s3, load_s4, load_s5;

	// A stage loads when it is empty or its content moves on.
	assign load_s5   = !vld_s5 || mix_ready;
	assign load_s4   = !vld_s4 || load_s5;
	assign load_s3   = !vld_s3 || load_s4;
	assign load_s2   = !vld_s2 || load_s3;
	assign load_s1   = !vld_s1 || load_s2;
	assign cmd_ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (load_s1) vld_s1 <= cmd_valid;
			if (load_s2) vld_s2 <= vld_s1;
			if (load_s3) vld_s3 <= vld_s2;
			if (load_s4) vld_s4 <= vld_s3;
			if (load_s5) vld_s5 <= vld_s4;
		end
	end

	// Stage 1: clamp each axis to its limit.
	speed_t vx_s1, vy_s1, vw_s1;

	always_ff @(posedge clk) begin
		if (load_s1) begin
			vx_s1 <= clamp_axis(cmd.speed_forward, cfg.limit_forward);
			vy_s1 <= clamp_axis(cmd.speed_sideways, cfg.limit_sideways);
			vw_s1 <= clamp_axis(cmd.rate_yaw, cfg.limit_yaw);
		end
	end

	// Stage 2: front and rear rotation magnitudes from the yaw rate.
	logic [SPEED_W-1:0]    yaw_abs;
	logic [SPEED_W-2:0]    yaw_mag;
	logic [PROD_ROT_W-1:0] prod_front;
	logic [PROD_ROT_W-1:0] prod_rear;
	speed_t                vx_s2, vy_s2;
	logic [ROT_W-1:0]      rot_front_s2, rot_rear_s2;
	logic                  yaw_neg_s2;

	assign yaw_abs    = vw_s1[SPEED_W-1] ? SPEED_W'(-vw_s1) : SPEED_W'(vw_s1);
	assign yaw_mag    = yaw_abs[SPEED_W-2:0];
	assign prod_front = PROD_ROT_W'(yaw_mag) * PROD_ROT_W'(cfg.ratio_front);
	assign prod_rear  = PROD_ROT_W'(yaw_mag) * PROD_ROT_W'(cfg.ratio_rear);

	always_ff @(posedge clk) begin
		if (load_s2) begin
			vx_s2        <= vx_s1;
			vy_s2        <= vy_s1;
			rot_front_s2 <= prod_front[PROD_ROT_W-1:FRAC_W];
			rot_rear_s2  <= prod_rear[PROD_ROT_W-1:FRAC_W];
			yaw_neg_s2   <= vw_s1[SPEED_W-1];
		end
	end

	// Stage 3: mix the four wheels and split each sum into sign and magnitude.
	logic signed [SUM_W-1:0] x_ext, y_ext, rot_f, rot_r;
	logic signed [SUM_W-1:0] sum [NUM_WHEELS];
	logic signed [SUM_W-1:0] sum_abs [NUM_WHEELS];
	logic [MAG_W-1:0]        smag_s3 [NUM_WHEELS];
	logic [NUM_WHEELS-1:0]   sneg_s3;

	always_comb begin
		x_ext = SUM_W'(vx_s2);
		y_ext = SUM_W'(vy_s2);
		rot_f = $signed({{(SUM_W-ROT_W){1'b0}}, rot_front_s2});
		rot_r = $signed({{(SUM_W-ROT_W){1'b0}}, rot_rear_s2});
		if (yaw_neg_s2) begin
			rot_f = -rot_f;
			rot_r = -rot_r;
		end
		sum[WHEEL_FL] = x_ext - y_ext + rot_f;
		sum[WHEEL_FR] = x_ext + y_ext + rot_f;
		sum[WHEEL_RR] = y_ext - x_ext + rot_r;
		sum[WHEEL_RL] = -x_ext - y_ext + rot_r;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			sum_abs[i] = sum[i][SUM_W-1] ? -sum[i] : sum[i];
		end
	end

	always_ff @(posedge clk) begin
		if (load_s3) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				smag_s3[i] <= sum_abs[i][MAG_W-1:0];
				sneg_s3[i] <= sum[i][SUM_W-1];
			end
		end
	end

	// Stage 4: scale each magnitude by the rpm ratio, truncating toward zero.
	logic [PROD_RPM_W-1:0] prod_rpm [NUM_WHEELS];
	logic [SCALED_W-1:0]   pmag_s4 [NUM_WHEELS];
	logic [NUM_WHEELS-1:0] pneg_s4;

	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			prod_rpm[i] = PROD_RPM_W'(smag_s3[i]) * PROD_RPM_W'(cfg.ratio_rpm);
		end
	end

	always_ff @(posedge clk) begin
		if (load_s4) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				pmag_s4[i] <= prod_rpm[i][PROD_RPM_W-1:FRAC_W];
			end
			pneg_s4 <= sneg_s3;
		end
	end

	// Stage 5: saturate to signed 16 bits and keep each magnitude for the peak search.
	speed_t              rpm_d [NUM_WHEELS];
	logic [PEAK_W-1:0]   mag_d [NUM_WHEELS];
	mix_t                mix_s5;

	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			if (pneg_s4[i]) begin
				if (pmag_s4[i] > NEG_MAX) begin
					mag_d[i] = NEG_MAX[PEAK_W-1:0];
				end else begin
					mag_d[i] = pmag_s4[i][PEAK_W-1:0];
				end
				rpm_d[i] = -mag_d[i];
			end else begin
				if (pmag_s4[i] > POS_MAX) begin
					mag_d[i] = POS_MAX[PEAK_W-1:0];
				end else begin
					mag_d[i] = pmag_s4[i][PEAK_W-1:0];
				end
				rpm_d[i] = mag_d[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s5) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				mix_s5.rpm[i] <= rpm_d[i];
				mix_s5.mag[i] <= mag_d[i];
			end
		end
	end

	assign mix_valid = vld_s5;
	assign mix       = mix_s5;

endmodule

// ===== rtl/core/mwsm_peak.sv =====
// Two-stage peak search, limit compare and numerator product for the scaling divider.
module mwsm_peak (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [mwsm_pkg::LIMIT_W-1:0]     limit_wheel,
	input  logic                             mix_valid,
	output logic                             mix_ready,
	input  mwsm_pkg::mix_t                   mix,
	output logic                             scale_valid,
	input  logic                             scale_ready,
	output mwsm_pkg::scale_t                 scale
);
	import mwsm_pkg::*;

	logic vld_s1, vld_s2;
	logic load_s1, load_s2;

	assign load_s2   = !vld_s2 || scale_ready;
	assign load_s1   = !vld_s1 || load_s2;
	assign mix_ready = load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (load_s1) vld_s1 <= mix_valid;
			if (load_s2) vld_s2 <= vld_s1;
		end
	end

	// Stage 1: two-level maximum tree and the compare against the wheel limit.
	logic [PEAK_W-1:0] max_front, max_rear, peak_d;
	logic [PEAK_W-1:0] peak_s1;
	logic              scaled_s1;
	mix_t              mix_s1;

	always_comb begin
		max_front = (mix.mag[WHEEL_FL] > mix.mag[WHEEL_FR]) ? mix.mag[WHEEL_FL]
			: mix.mag[WHEEL_FR];
		max_rear  = (mix.mag[WHEEL_RR] > mix.mag[WHEEL_RL]) ? mix.mag[WHEEL_RR]
			: mix.mag[WHEEL_RL];
		peak_d    = (max_front > max_rear) ? max_front : max_rear;
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			mix_s1    <= mix;
			peak_s1   <= peak_d;
			scaled_s1 <= peak_d > PEAK_W'(limit_wheel);
		end
	end

	// Stage 2: numerator of each wheel's scaling, magnitude times the limit.
	scale_t scale_s2;

	always_ff @(posedge clk) begin
		if (load_s2) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				scale_s2.num[i] <= NUM_W'(mix_s1.mag[i]) * NUM_W'(limit_wheel);
			end
			scale_s2.rpm    <= mix_s1.rpm;
			scale_s2.peak   <= peak_s1;
			scale_s2.scaled <= scaled_s1;
		end
	end

	assign scale_valid = vld_s2;
	assign scale       = scale_s2;

endmodule

// ===== rtl/core/mwsm_div.sv =====
// Pipelined restoring divider: four wheel quotients, DIV_STEPS quotient bits per stage.
module mwsm_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              scale_valid,
	output logic              scale_ready,
	input  mwsm_pkg::scale_t  scale,
	output logic              quo_valid,
	input  logic              quo_ready,
	output mwsm_pkg::quo_t    quo
);
	import mwsm_pkg::*;

	logic [DIV_STAGES-1:0] vld_s;
	logic [DIV_STAGES:0]   load;
	quo_t                  dat_s [DIV_STAGES];
	quo_t                  entry;

	// Quotient fits in QUO_W bits, so the upper numerator bits start as remainder.
	always_comb begin
		entry.rpm    = scale.rpm;
		entry.peak   = scale.peak;
		entry.scaled = scale.scaled;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			entry.rem[i] = scale.num[i][NUM_W-1:QUO_W];
			entry.low[i] = scale.num[i][QUO_W-1:0];
			entry.quo[i] = '0;
		end
	end

	assign load[DIV_STAGES] = quo_ready;
	assign scale_ready      = load[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		quo_t src;
		quo_t nxt;
		logic src_valid;

		if (k == 0) begin : g_first
			assign src       = entry;
			assign src_valid = scale_valid;
		end else begin : g_next
			assign src       = dat_s[k-1];
			assign src_valid = vld_s[k-1];
		end

		assign load[k] = !vld_s[k] || load[k+1];

		// Restoring steps: shift in one numerator bit, subtract the peak when it fits.
		always_comb begin
			logic [PEAK_W:0] trial;
			logic [PEAK_W:0] diff;
			logic            qbit;
			nxt = src;
			for (int i = 0; i < NUM_WHEELS; i++) begin
				for (int s = 0; s < DIV_STEPS; s++) begin
					trial = {nxt.rem[i], nxt.low[i][QUO_W-1]};
					diff  = trial - {1'b0, src.peak};
					qbit  = trial >= {1'b0, src.peak};
					nxt.low[i] = {nxt.low[i][QUO_W-2:0], 1'b0};
					nxt.rem[i] = qbit ? diff[PEAK_W-1:0] : trial[PEAK_W-1:0];
					nxt.quo[i] = {nxt.quo[i][QUO_W-2:0], qbit};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (load[k]) begin
				vld_s[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (load[k]) begin
				dat_s[k] <= nxt;
			end
		end
	end

	assign quo_valid = vld_s[DIV_STAGES-1];
	assign quo       = dat_s[DIV_STAGES-1];

endmodule

// ===== rtl/core/mecanum_wheel_speed_mixer.sv =====
// Top level of the mecanum wheel speed mixer: config registers, pipeline and output register.
//
// Usage: a chassis command (forward, sideways, yaw rate) is a transfer on the cmd channel
// (cmd_valid/cmd_ready). The four wheel rpm targets and the was_scaled flag leave as one
// transfer on the wheel channel (wheel_valid/wheel_ready), one result per command, in order.
// Configuration registers are written through cfg_write/cfg_index/cfg_data, one per cycle,
// with no handshake; writes to an index past the last register are dropped.
// A command passes 5 mix stages, 2 peak stages, 5 divider stages and 1 output register
// on its way to wheel_valid. Throughput: one command per cycle while the receiver keeps up;
// each divider stage resolves 3 quotient bits for all four wheels, which sets the stage count.
// Reset clears every valid bit and loads the default configuration.
// When the receiver stalls, results pile up stage by stage; empty stages keep taking
// commands, and cmd_ready drops only once all 13 stages hold a result.
`include "mecanum_wheel_speed_mixer_assert.svh"

module mecanum_wheel_speed_mixer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cmd_valid,
	output logic                                cmd_ready,
	input  mwsm_pkg::cmd_t                      cmd,
	output logic                                wheel_valid,
	input  logic                                wheel_ready,
	output mwsm_pkg::wheel_t                    wheel,
	input  logic                                cfg_write,
	input  logic [mwsm_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [mwsm_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import mwsm_pkg::*;

	// Configuration register file.
	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_write) begin
			case (cfg_index_t'(cfg_index))
				CFG_LIMIT_FORWARD:  cfg_q.limit_forward  <= cfg_data[LIMIT_W-1:0];
				CFG_LIMIT_SIDEWAYS: cfg_q.limit_sideways <= cfg_data[LIMIT_W-1:0];
				CFG_LIMIT_YAW:      cfg_q.limit_yaw      <= cfg_data[LIMIT_W-1:0];
				CFG_RATIO_FRONT:    cfg_q.ratio_front    <= cfg_data[RATIO_W-1:0];
				CFG_RATIO_REAR:     cfg_q.ratio_rear     <= cfg_data[RATIO_W-1:0];
				CFG_RATIO_RPM:      cfg_q.ratio_rpm      <= cfg_data[RATIO_W-1:0];
				CFG_LIMIT_WHEEL:    cfg_q.limit_wheel    <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Pipeline sections.
	logic   mix_valid, mix_ready;
	mix_t   mix;
	logic   scale_valid, scale_ready;
	scale_t scale;
	logic   quo_valid, quo_ready;
	quo_t   quo;

	mwsm_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.mix_valid (mix_valid),
		.mix_ready (mix_ready),
		.mix       (mix)
	);

	mwsm_peak u_peak (
		.clk         (clk),
		.arst_n      (arst_n),
		.limit_wheel (cfg_q.limit_wheel),
		.mix_valid   (mix_valid),
		.mix_ready   (mix_ready),
		.mix         (mix),
		.scale_valid (scale_valid),
		.scale_ready (scale_ready),
		.scale       (scale)
	);

	mwsm_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.scale_valid (scale_valid),
		.scale_ready (scale_ready),
		.scale       (scale),
		.quo_valid   (quo_valid),
		.quo_ready   (quo_ready),
		.quo         (quo)
	);

	// Output stage: pick the scaled quotient with the wheel's sign, or the unscaled speed.
	speed_t fin [NUM_WHEELS];
	wheel_t wheel_d;
	wheel_t wheel_q;
	logic   wheel_valid_q;
	logic   load_out;

	always_comb begin
		for (int i = 0; i < NUM_WHEELS; i++) begin
			if (!quo.scaled) begin
				fin[i] = quo.rpm[i];
			end else if (quo.rpm[i][SPEED_W-1]) begin
				fin[i] = -{1'b0, quo.quo[i]};
			end else begin
				fin[i] = {1'b0, quo.quo[i]};
			end
		end
		wheel_d.rpm_front_left  = fin[WHEEL_FL];
		wheel_d.rpm_front_right = fin[WHEEL_FR];
		wheel_d.rpm_rear_right  = fin[WHEEL_RR];
		wheel_d.rpm_rear_left   = fin[WHEEL_RL];
		wheel_d.was_scaled      = quo.scaled;
	end

	assign load_out  = !wheel_valid_q || wheel_ready;
	assign quo_ready = load_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_valid_q <= 1'b0;
		end else if (load_out) begin
			wheel_valid_q <= quo_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			wheel_q <= wheel_d;
		end
	end

	assign wheel_valid = wheel_valid_q;
	assign wheel       = wheel_q;

	// Magnitudes of the presented wheel speeds, for the checks below.
	logic [PEAK_W-1:0] out_mag [NUM_WHEELS];
	logic [PEAK_W-1:0] lim_ext;
	logic              all_within;
	logic              any_at_limit;

	always_comb begin
		out_mag[WHEEL_FL] = wheel_q.rpm_front_left[SPEED_W-1]
			? PEAK_W'(-wheel_q.rpm_front_left) : PEAK_W'(wheel_q.rpm_front_left);
		out_mag[WHEEL_FR] = wheel_q.rpm_front_right[SPEED_W-1]
			? PEAK_W'(-wheel_q.rpm_front_right) : PEAK_W'(wheel_q.rpm_front_right);
		out_mag[WHEEL_RR] = wheel_q.rpm_rear_right[SPEED_W-1]
			? PEAK_W'(-wheel_q.rpm_rear_right) : PEAK_W'(wheel_q.rpm_rear_right);
		out_mag[WHEEL_RL] = wheel_q.rpm_rear_left[SPEED_W-1]
			? PEAK_W'(-wheel_q.rpm_rear_left) : PEAK_W'(wheel_q.rpm_rear_left);
		lim_ext      = PEAK_W'(cfg_q.limit_wheel);
		all_within   = 1'b1;
		any_at_limit = 1'b0;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			all_within   = all_within && (out_mag[i] <= lim_ext);
			any_at_limit = any_at_limit || (out_mag[i] == lim_ext);
		end
	end

	// No presented wheel ever exceeds the wheel limit, scaled or not.
	`MWSM_ASSERT_IMPLIES(a_wheels_within_limit, clk, arst_n, wheel_valid_q, all_within)
	// After scaling, the peak wheel lands exactly on the limit.
	`MWSM_ASSERT_IMPLIES(a_scaled_peak_on_limit, clk, arst_n, wheel_valid_q && wheel_q.was_scaled, any_at_limit)
	// The command side only stalls when the whole pipeline backs up behind the output.
	`MWSM_ASSERT_IMPLIES(a_stall_from_output, clk, arst_n, !cmd_ready, wheel_valid_q && !wheel_ready)
	// A taken result with nothing behind it leaves the output register empty.
	`MWSM_ASSERT_NEXT(a_output_drains, clk, arst_n, wheel_valid_q && wheel_ready && !quo_valid, !wheel_valid_q)

endmodule
